>>> rtl/core/ntd_pkg.sv
// Shared constants, control-word type and microcode table for the n-th prime block.
// Used by nth_prime_trial_division_top; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ntd_pkg;

    localparam int MAX_PRIMES = 1024;
    localparam int VALUE_BITS = 16;
    localparam int INDEX_BITS = 12;
    localparam int IDX_W      = $clog2(MAX_PRIMES);
    localparam int CNT_W      = $clog2(MAX_PRIMES + 1);
    localparam int CMP_W      = (CNT_W > INDEX_BITS ? CNT_W : INDEX_BITS) + 1;
    localparam int DCNT_W     = $clog2(VALUE_BITS + 1);

    localparam logic [VALUE_BITS-1:0] FIRST_PRIME = VALUE_BITS'(2);
    localparam logic [VALUE_BITS:0]   FIRST_ODD   = (VALUE_BITS + 1)'(3);

    localparam int STEP_W = 4;
    localparam int OP_W   = 4;
    localparam int COND_W = 4;

    // Datapath operations.
    localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
    localparam logic [OP_W-1:0] OP_K_INIT    = 4'd2;
    localparam logic [OP_W-1:0] OP_READ      = 4'd3;
    localparam logic [OP_W-1:0] OP_SQUARE    = 4'd4;
    localparam logic [OP_W-1:0] OP_DIV_START = 4'd5;
    localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd6;
    localparam logic [OP_W-1:0] OP_K_INC     = 4'd7;
    localparam logic [OP_W-1:0] OP_APPEND    = 4'd8;
    localparam logic [OP_W-1:0] OP_CAND_INC  = 4'd9;
    localparam logic [OP_W-1:0] OP_RES_OK    = 4'd10;
    localparam logic [OP_W-1:0] OP_RES_ERR   = 4'd11;

    // Jump conditions.
    localparam logic [COND_W-1:0] C_NEVER      = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS     = 4'd1;
    localparam logic [COND_W-1:0] C_NO_START   = 4'd2;
    localparam logic [COND_W-1:0] C_BAD_INDEX  = 4'd3;
    localparam logic [COND_W-1:0] C_COUNT_DONE = 4'd4;
    localparam logic [COND_W-1:0] C_CAND_OVF   = 4'd5;
    localparam logic [COND_W-1:0] C_K_END      = 4'd6;
    localparam logic [COND_W-1:0] C_SQ_GT      = 4'd7;
    localparam logic [COND_W-1:0] C_DIV_MORE   = 4'd8;
    localparam logic [COND_W-1:0] C_REM_ZERO   = 4'd9;

    // Program steps.
    localparam logic [STEP_W-1:0] S_WAIT     = 4'd0;
    localparam logic [STEP_W-1:0] S_CHECK    = 4'd1;
    localparam logic [STEP_W-1:0] S_LOOP     = 4'd2;
    localparam logic [STEP_W-1:0] S_OVF      = 4'd3;
    localparam logic [STEP_W-1:0] S_K_INIT   = 4'd4;
    localparam logic [STEP_W-1:0] S_READ     = 4'd5;
    localparam logic [STEP_W-1:0] S_SQUARE   = 4'd6;
    localparam logic [STEP_W-1:0] S_SQ_CHECK = 4'd7;
    localparam logic [STEP_W-1:0] S_DIVIDE   = 4'd8;
    localparam logic [STEP_W-1:0] S_REM      = 4'd9;
    localparam logic [STEP_W-1:0] S_BACK     = 4'd10;
    localparam logic [STEP_W-1:0] S_APPEND   = 4'd11;
    localparam logic [STEP_W-1:0] S_NEXT     = 4'd12;
    localparam logic [STEP_W-1:0] S_DONE     = 4'd13;
    localparam logic [STEP_W-1:0] S_ERROR    = 4'd14;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // The program: the operation runs in its step; when the condition holds the
    // sequencer jumps to the target, otherwise it falls through to the next step.
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            S_WAIT:     w = '{OP_LOAD,      C_NO_START,   S_WAIT};
            S_CHECK:    w = '{OP_NOP,       C_BAD_INDEX,  S_ERROR};
            S_LOOP:     w = '{OP_NOP,       C_COUNT_DONE, S_DONE};
            S_OVF:      w = '{OP_NOP,       C_CAND_OVF,   S_ERROR};
            S_K_INIT:   w = '{OP_K_INIT,    C_NEVER,      S_WAIT};
            S_READ:     w = '{OP_READ,      C_K_END,      S_APPEND};
            S_SQUARE:   w = '{OP_SQUARE,    C_NEVER,      S_WAIT};
            S_SQ_CHECK: w = '{OP_DIV_START, C_SQ_GT,      S_APPEND};
            S_DIVIDE:   w = '{OP_DIV_STEP,  C_DIV_MORE,   S_DIVIDE};
            S_REM:      w = '{OP_K_INC,     C_REM_ZERO,   S_NEXT};
            S_BACK:     w = '{OP_NOP,       C_ALWAYS,     S_READ};
            S_APPEND:   w = '{OP_APPEND,    C_NEVER,      S_WAIT};
            S_NEXT:     w = '{OP_CAND_INC,  C_ALWAYS,     S_LOOP};
            S_DONE:     w = '{OP_RES_OK,    C_ALWAYS,     S_WAIT};
            S_ERROR:    w = '{OP_RES_ERR,   C_ALWAYS,     S_WAIT};
            default:    w = '{OP_NOP,       C_ALWAYS,     S_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/nth_prime_trial_division_top.sv
// N-th prime by trial division: microcoded sequencer, prime table RAM and bit-serial divider.
// Depends on ntd_pkg for constants and the microcode table.
//
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_ready    i_prime_index
//  out      output     o_out_valid / i_out_ready  o_prime_value, o_index_error
//
// A request with a bad index goes from the index check straight to the error step. Otherwise
// each odd candidate is divided by the stored odd primes in turn; the bit-serial remainder loop
// of the divider dominates, so index 1024 takes the longest.
// Reset is synchronous and active low; it clears the step counter and the output valid.
// The next request is taken once the program is back at its first step and the output
// register is free or being emptied in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module nth_prime_trial_division_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [ntd_pkg::INDEX_BITS-1:0] i_prime_index,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [ntd_pkg::VALUE_BITS-1:0]     o_prime_value,
    output logic                               o_index_error
);
    import ntd_pkg::*;

    logic [STEP_W-1:0]       r_step, n_step;
    logic                    r_out_valid;
    logic [VALUE_BITS-1:0]   r_prime;
    logic                    r_err;

    logic [INDEX_BITS-1:0]   r_n;
    logic [VALUE_BITS:0]     r_cand;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_k;
    logic [VALUE_BITS-1:0]   r_last;
    logic [VALUE_BITS-1:0]   r_rd;
    logic [VALUE_BITS-1:0]   r_div_p;
    logic [2*VALUE_BITS-1:0] r_sq;
    logic [VALUE_BITS-1:0]   r_rem;
    logic [VALUE_BITS-1:0]   r_quo;
    logic [DCNT_W-1:0]       r_dcnt;

    logic [VALUE_BITS-1:0]   r_table [MAX_PRIMES];

    t_uword                  uw;
    logic                    start;
    logic                    cond_true;
    logic [VALUE_BITS:0]     trial;

    assign uw          = ucode(r_step);
    assign o_in_ready  = (r_step == S_WAIT) && (!r_out_valid || i_out_ready);
    assign start       = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_prime_value = r_prime;
    assign o_index_error = r_err;

    // One restoring step of the remainder: shift in the next dividend bit, subtract if it fits.
    assign trial = {r_rem, r_quo[VALUE_BITS-1]};

    always_comb begin
        unique case (uw.cond)
            C_NEVER:      cond_true = 1'b0;
            C_ALWAYS:     cond_true = 1'b1;
            C_NO_START:   cond_true = !start;
            C_BAD_INDEX:  cond_true = (r_n == '0)
                                   || (CMP_W'(r_n) > CMP_W'(MAX_PRIMES));
            C_COUNT_DONE: cond_true = CMP_W'(r_count) >= CMP_W'(r_n);
            C_CAND_OVF:   cond_true = r_cand[VALUE_BITS];
            C_K_END:      cond_true = r_k >= r_count;
            C_SQ_GT:      cond_true = (r_div_p == '0)
                                   || (r_sq > (2*VALUE_BITS)'(r_cand));
            C_DIV_MORE:   cond_true = r_dcnt != DCNT_W'(1);
            C_REM_ZERO:   cond_true = r_rem == '0;
            default:      cond_true = 1'b0;
        endcase
        n_step = cond_true ? uw.target : r_step + STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (uw.op == OP_RES_OK || uw.op == OP_RES_ERR) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (uw.op)
            OP_LOAD: begin
                if (start) begin
                    r_n     <= i_prime_index;
                    r_cand  <= FIRST_ODD;
                    r_count <= CNT_W'(1);
                    r_last  <= FIRST_PRIME;
                end
            end
            OP_K_INIT:   r_k <= CNT_W'(1);
            OP_SQUARE: begin
                r_sq    <= {{VALUE_BITS{1'b0}}, r_rd} * {{VALUE_BITS{1'b0}}, r_rd};
                r_div_p <= r_rd;
            end
            OP_DIV_START: begin
                r_rem  <= '0;
                r_quo  <= r_cand[VALUE_BITS-1:0];
                r_dcnt <= DCNT_W'(VALUE_BITS);
            end
            OP_DIV_STEP: begin
                if (trial >= {1'b0, r_div_p}) begin
                    r_rem <= VALUE_BITS'(trial - {1'b0, r_div_p});
                end else begin
                    r_rem <= trial[VALUE_BITS-1:0];
                end
                r_quo  <= {r_quo[VALUE_BITS-2:0], 1'b0};
                r_dcnt <= r_dcnt - DCNT_W'(1);
            end
            OP_K_INC:    r_k <= r_k + CNT_W'(1);
            OP_APPEND: begin
                r_last  <= r_cand[VALUE_BITS-1:0];
                r_count <= r_count + CNT_W'(1);
            end
            OP_CAND_INC: r_cand <= r_cand + (VALUE_BITS + 1)'(2);
            OP_RES_OK: begin
                r_prime <= r_last;
                r_err   <= 1'b0;
            end
            OP_RES_ERR: begin
                r_prime <= '0;
                r_err   <= 1'b1;
            end
            default: ;
        endcase
    end

    // Prime table: entry 0 is never stored; the constant 2 is loaded into r_last at the start.
    always_ff @(posedge i_clk) begin
        if (uw.op == OP_APPEND) begin
            r_table[r_count[IDX_W-1:0]] <= r_cand[VALUE_BITS-1:0];
        end
        if (uw.op == OP_READ) begin
            r_rd <= r_table[r_k[IDX_W-1:0]];
        end
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_index_error |-> o_prime_value == '0)
        else $error("error result carries a non-zero value");

    a_odd_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_index_error |-> o_prime_value[0] || o_prime_value == FIRST_PRIME)
        else $error("good result is an even number other than two");

    a_start_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_step == S_CHECK)
        else $error("accepted transfer did not reach the index check");

    a_div_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == S_DIVIDE |=> $stable(r_cand) && $stable(r_div_p))
        else $error("operands changed while the divider was running");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for nth_prime_trial_division_top: directed and random requests under varying idling.
// Depends on ntd_pkg for widths and the table depth, and on the top level of the block.
`timescale 1ns / 1ps

module tb_top;

    import ntd_pkg::MAX_PRIMES;
    import ntd_pkg::VALUE_BITS;
    import ntd_pkg::INDEX_BITS;

    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 1;
    // The deepest request runs with nothing transferred until its result is out; the limit has to cover that run.
    localparam int unsigned QUIET_LIMIT = 4_000_000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned MAX_SHOWN = 10;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  index_error;
    } t_prime_answer;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [INDEX_BITS-1:0] i_prime_index = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [VALUE_BITS-1:0] o_prime_value;
    logic                  o_index_error;

    // Own copy of the block's state, rebuilt on every request just as the block does.
    int unsigned     prime_list [MAX_PRIMES];

    t_prime_answer pending_answers [$];
    int unsigned   mismatches = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;

    nth_prime_trial_division_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_prime_index (i_prime_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_prime_value (o_prime_value),
        .o_index_error (o_index_error)
    );

    always #6 i_clk = ~i_clk;

    // Trial division by the odd primes held so far, stopping once the square passes the
    // candidate or a divisor is found; a bad index, or a candidate running out of range, ends with an error.
    function automatic t_prime_answer predict_prime(input logic [INDEX_BITS-1:0] idx);
        t_prime_answer   ans;
        int unsigned     count;
        int unsigned     k;
        longint unsigned cand;
        longint unsigned p;
        bit              composite;
        ans.value = '0;
        ans.index_error = 1'b1;
        if (idx == 0 || idx > MAX_PRIMES) begin
            return ans;
        end
        prime_list[0] = 2;
        count = 1;
        cand = 3;
        while (count < idx) begin
            if (cand > VALUE_MAX) begin
                return ans;
            end
            composite = 1'b0;
            for (k = 1; k < count; k++) begin
                p = prime_list[k];
                if (p * p > cand) begin
                    break;
                end
                if (cand % p == 0) begin
                    composite = 1'b1;
                    break;
                end
            end
            if (!composite) begin
                prime_list[count] = int'(cand);
                count++;
            end
            cand += 2;
        end
        ans.value = prime_list[count-1][VALUE_BITS-1:0];
        ans.index_error = 1'b0;
        return ans;
    endfunction

    // Called at a rising edge; returns at the edge of the transfer with valid still high,
    // so that a following request can go out back to back.
    task automatic send_request(input logic [INDEX_BITS-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_prime_index <= idx;
        @(negedge i_clk);
        while (!o_in_ready) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        pending_answers.push_back(predict_prime(idx));
    endtask

    task automatic test_bad_index();
        send_request('0);
        send_request('1);
        send_request(INDEX_BITS'(MAX_PRIMES + 1));
        send_request(INDEX_BITS'(2048));
        send_request(INDEX_BITS'(12'h555));
        send_request(INDEX_BITS'(12'haaa));
    endtask

    // Index one needs no candidate; nine and twenty-five are squares of stored primes.
    task automatic test_first_primes();
        send_request(INDEX_BITS'(1));
        send_request(INDEX_BITS'(2));
        send_request(INDEX_BITS'(3));
        send_request(INDEX_BITS'(4));
        send_request(INDEX_BITS'(5));
        send_request(INDEX_BITS'(6));
        send_request(INDEX_BITS'(10));
        send_request(INDEX_BITS'(1));
        send_request(INDEX_BITS'(31));
    endtask

    task automatic test_table_depth();
        send_request(INDEX_BITS'(MAX_PRIMES));
        send_request(INDEX_BITS'(2));
    endtask

    // Mostly short searches, a few longer ones, and about a fifth rejected indexes.
    task automatic test_random_requests(input int unsigned n_items);
        int unsigned           pick;
        logic [INDEX_BITS-1:0] idx;
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                idx = '0;
            end else if (pick < 20) begin
                idx = INDEX_BITS'($urandom_range((1 << INDEX_BITS) - 1, MAX_PRIMES + 1));
            end else if (pick < 26) begin
                idx = INDEX_BITS'($urandom_range(100, 41));
            end else begin
                idx = INDEX_BITS'($urandom_range(40, 1));
            end
            send_request(idx);
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Signals change only at rising edges, so a handshake seen at the falling edge is the
    // transfer of the next rising edge.
    always @(negedge i_clk) begin
        t_prime_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("Unexpected result: value %0d error %0b",
                             o_prime_value, o_index_error);
                end
            end else begin
                want = pending_answers.pop_front();
                if (o_prime_value !== want.value || o_index_error !== want.index_error) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("Mismatch: expected value %0d error %0b, got value %0d error %0b",
                                 want.value, want.index_error, o_prime_value, o_index_error);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout after %0d cycles without a transfer", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 76;
        test_bad_index();
        test_first_primes();
        test_table_depth();
        test_random_requests(34);

        send_idle_pct = 76;
        recv_idle_pct = 33;
        test_random_requests(33);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_requests(33);

        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
